>>> sv/mlp_pkg.sv
// Shared types and constants for the two-layer tanh perceptron core.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none
package mlp_pkg;

    localparam int VALUE_W   = 16;
    localparam int OUT_W     = 14;
    localparam int SUM_CLAMP = 16384;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_acc;   // start a new node sum
        logic mac;         // accumulate feature/hidden times weight
        logic add_bias;    // accumulate bias << 12
        logic finish;      // round, clamp, tanh into result register
        logic src_hidden;  // multiplicand from hidden store
    } t_dp_cmd;

    function automatic logic signed [13:0] tanh_pt(input logic [4:0] k);
        logic signed [13:0] t;
        case (k)
            5'd0:  t = 14'sd0;
            5'd1:  t = 14'sd1003;
            5'd2:  t = 14'sd1893;
            5'd3:  t = 14'sd2602;
            5'd4:  t = 14'sd3119;
            5'd5:  t = 14'sd3475;
            5'd6:  t = 14'sd3707;
            5'd7:  t = 14'sd3856;
            5'd8:  t = 14'sd3949;
            5'd9:  t = 14'sd4006;
            5'd10: t = 14'sd4041;
            5'd11: t = 14'sd4062;
            5'd12: t = 14'sd4076;
            5'd13: t = 14'sd4084;
            5'd14: t = 14'sd4089;
            5'd15: t = 14'sd4091;
            default: t = 14'sd4096;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

>>> sv/mlp_datapath.sv
// Datapath: weight memory, feature and hidden stores, one MAC unit and tanh.
// Depends on mlp_pkg for the command struct and the tanh table.
`timescale 1ns / 1ps
`default_nettype none
module mlp_datapath
    import mlp_pkg::*;
#(
    parameter int INPUT_COUNT  = 8,
    parameter int HIDDEN_COUNT = 8,
    parameter int WEIGHT_COUNT = 90,
    parameter int WADDR_W      = 7,
    parameter int FADDR_W      = 3,
    parameter int HADDR_W      = 3
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_weight,
    input  wire logic                      i_wr_feature,
    input  wire logic [6:0]                i_wr_index,
    input  wire logic signed [VALUE_W-1:0] i_wr_value,
    input  wire logic [WADDR_W-1:0]        i_rd_waddr,
    input  wire logic [FADDR_W-1:0]        i_rd_faddr,
    input  wire logic [HADDR_W-1:0]        i_rd_haddr,
    input  wire logic                      i_hid_we,
    input  wire logic [HADDR_W-1:0]        i_hid_waddr,
    input  wire t_dp_cmd                   i_cmd,
    output logic signed [OUT_W-1:0]        o_result
);

    logic signed [VALUE_W-1:0] r_wmem [WEIGHT_COUNT];
    logic signed [VALUE_W-1:0] r_feat [INPUT_COUNT];
    logic signed [VALUE_W-1:0] r_hid  [HIDDEN_COUNT];
    logic signed [VALUE_W-1:0] r_w, r_x;
    logic signed [VALUE_W-1:0] r_bias_w;
    logic signed [31:0]        r_prod;
    logic signed [47:0]        r_acc;
    logic signed [OUT_W-1:0]   r_result;
    logic                      r_prod_v;
    logic                      r_bias_v;

    logic signed [47:0] rnd;
    logic signed [15:0] clamped;
    logic [14:0]        mag;
    logic [4:0]         k;
    logic [9:0]         f;
    logic signed [13:0] lo, hi;
    logic [23:0]        interp;
    logic [13:0]        y;
    logic signed [47:0] n_acc;

    always_ff @(posedge i_clk) begin
        if (i_wr_weight && (32'(i_wr_index) < 32'(WEIGHT_COUNT)))
            r_wmem[WADDR_W'(i_wr_index)] <= i_wr_value;
        r_w <= r_wmem[i_rd_waddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_feature && ({1'b0, i_wr_index} < 8'(INPUT_COUNT)))
            r_feat[i_wr_index[FADDR_W-1:0]] <= i_wr_value;
        if (i_hid_we)
            r_hid[i_hid_waddr] <= {{(VALUE_W-OUT_W){r_result[OUT_W-1]}}, r_result};
        r_x <= i_cmd.src_hidden ? r_hid[i_rd_haddr] : r_feat[i_rd_faddr];
    end

    // Round to Q.12, clamp to +-4.0, then piecewise-linear tanh
    always_comb begin
        rnd = (r_acc + 48'sd2048) >>> 12;
        if (rnd > 48'(SUM_CLAMP))       clamped = 16'(SUM_CLAMP);
        else if (rnd < -48'(SUM_CLAMP)) clamped = -16'(SUM_CLAMP);
        else                            clamped = rnd[15:0];
        mag    = clamped[15] ? 15'(-clamped) : clamped[14:0];
        k      = mag[14:10];
        f      = mag[9:0];
        lo     = tanh_pt(k);
        hi     = tanh_pt(k + 5'd1);
        interp = 24'(hi - lo) * 24'(f) + 24'd512;
        y      = (k >= 5'd16) ? 14'd4096 : 14'(lo + 14'(interp[23:10]));
        n_acc  = r_acc;
        if (i_cmd.clear_acc)       n_acc = '0;
        else begin
            if (r_prod_v)          n_acc = n_acc + 48'(r_prod);
            if (r_bias_v)          n_acc = n_acc + (48'(r_bias_w) <<< 12);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_v <= i_cmd.mac;
        r_bias_v <= i_cmd.add_bias;
        r_prod   <= r_x * r_w;
        // keep the bias word in step with the product stage
        r_bias_w <= r_w;
        r_acc    <= n_acc;
        if (i_cmd.finish)
            r_result <= clamped[15] ? -$signed(y) : $signed(y);
    end

    assign o_result = r_result;

endmodule
`default_nettype wire

>>> sv/mlp_ctrl.sv
// Controller: sequences reads and MAC commands over all nodes of one pass.
// Depends on mlp_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none
module mlp_ctrl
    import mlp_pkg::*;
#(
    parameter int INPUT_COUNT  = 8,
    parameter int HIDDEN_COUNT = 8,
    parameter int OUTPUT_COUNT = 2,
    parameter int WADDR_W      = 7,
    parameter int FADDR_W      = 3,
    parameter int HADDR_W      = 3,
    parameter int OADDR_W      = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_out_free,
    output logic                    o_busy,
    output logic [WADDR_W-1:0]      o_rd_waddr,
    output logic [FADDR_W-1:0]      o_rd_faddr,
    output logic [HADDR_W-1:0]      o_rd_haddr,
    output logic                    o_hid_we,
    output logic [HADDR_W-1:0]      o_hid_waddr,
    output t_dp_cmd                 o_cmd,
    output logic                    o_emit,
    output logic [OADDR_W-1:0]      o_node,
    output logic                    o_node_last
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TERM  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DONE  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    localparam int CW = 6;
    t_state             r_state, n_state;
    logic [CW-1:0]      r_term;   // term within node, fan-in counts the bias
    logic [CW-1:0]      r_node;   // node across both layers
    logic [WADDR_W-1:0] r_waddr;
    logic [1:0]         r_drain;
    logic               r_layer2;

    logic [CW-1:0] fanin;
    assign fanin = r_layer2 ? CW'(HIDDEN_COUNT) : CW'(INPUT_COUNT);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) n_state = S_TERM;
            S_TERM:  if (r_term == fanin) n_state = S_DRAIN;
            S_DRAIN: if (r_drain == 2'd2) n_state = S_DONE;
            S_DONE:  n_state = r_layer2 ? S_EMIT : S_TERM;
            S_EMIT:  if (i_out_free)
                         n_state = (r_node == CW'(HIDDEN_COUNT + OUTPUT_COUNT - 1))
                                 ? S_IDLE : S_TERM;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_term   <= '0;
            r_node   <= '0;
            r_waddr  <= '0;
            r_drain  <= '0;
            r_layer2 <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_term <= '0; r_node <= '0; r_waddr <= '0; r_layer2 <= 1'b0;
                end
                S_TERM: begin
                    r_term  <= r_term + 1'b1;
                    r_waddr <= r_waddr + 1'b1;
                    r_drain <= '0;
                end
                S_DRAIN: r_drain <= r_drain + 1'b1;
                S_DONE: begin
                    r_term <= '0;
                    if (!r_layer2) begin
                        r_node <= r_node + 1'b1;
                        if (r_node == CW'(HIDDEN_COUNT - 1)) r_layer2 <= 1'b1;
                    end
                end
                S_EMIT: if (i_out_free) r_node <= r_node + 1'b1;
                default: ;
            endcase
        end
    end

    // Read issued in TERM; the memory output, the product and the accumulator are registered in turn
    logic r_mac_pipe, r_bias_pipe;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_pipe  <= 1'b0;
            r_bias_pipe <= 1'b0;
        end else begin
            r_mac_pipe  <= (r_state == S_TERM) && (r_term != fanin);
            r_bias_pipe <= (r_state == S_TERM) && (r_term == fanin);
        end
    end

    always_comb begin
        o_cmd.clear_acc  = (r_state == S_TERM) && (r_term == '0);
        o_cmd.mac        = r_mac_pipe;
        o_cmd.add_bias   = r_bias_pipe;
        o_cmd.finish     = (r_state == S_DRAIN) && (r_drain == 2'd2);
        o_cmd.src_hidden = r_layer2;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_rd_waddr  = r_waddr;
    assign o_rd_faddr  = r_term[FADDR_W-1:0];
    assign o_rd_haddr  = r_term[HADDR_W-1:0];
    assign o_hid_we    = (r_state == S_DONE) && !r_layer2;
    assign o_hid_waddr = r_node[HADDR_W-1:0];
    assign o_emit      = (r_state == S_EMIT) && i_out_free;
    assign o_node      = OADDR_W'(r_node - CW'(HIDDEN_COUNT));
    assign o_node_last = (r_node == CW'(HIDDEN_COUNT + OUTPUT_COUNT - 1));

endmodule
`default_nettype wire

>>> sv/mlp_tanh_inference_core.sv
// Two-layer tanh perceptron inference core: streaming ports around mlp_ctrl
// and mlp_datapath. Depends on mlp_pkg.
//
// Weight and feature items are taken one per cycle while no pass runs. A
// feature item with tlast starts a forward pass run on one multiply-
// accumulate unit; input is held off until the pass ends. Each node steps
// through weight-memory reads over its fan-in and its bias, a pipeline
// drain and a done state that stores hidden-layer results, and each output
// node then hands off its result. Results go out from a one-entry output
// register that lets the next node run while a result waits on tready.
`timescale 1ns / 1ps
`default_nettype none
module mlp_tanh_inference_core
    import mlp_pkg::*;
#(
    parameter int INPUT_COUNT  = 8,
    parameter int HIDDEN_COUNT = 8,
    parameter int OUTPUT_COUNT = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // index[6:0], value[22:7], zero pad
    input  wire logic        s_axis_tuser,   // op
    input  wire logic        s_axis_tlast,   // last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // out_value[13:0], zero pad
    output logic             m_axis_tuser,   // out_index
    output logic             m_axis_tlast    // out_last
);

    localparam int WEIGHT_COUNT = HIDDEN_COUNT * (INPUT_COUNT + 1)
                                + OUTPUT_COUNT * (HIDDEN_COUNT + 1);
    localparam int WADDR_W = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
    localparam int FADDR_W = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
    localparam int HADDR_W = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
    localparam int OADDR_W = 1;

    logic               busy, accept, emit, node_last, hid_we;
    logic [WADDR_W-1:0] rd_waddr;
    logic [FADDR_W-1:0] rd_faddr;
    logic [HADDR_W-1:0] rd_haddr, hid_waddr;
    logic [OADDR_W-1:0] node;
    t_dp_cmd            cmd;
    logic signed [OUT_W-1:0] result;

    logic                r_out_valid, r_out_last, r_out_idx;
    logic [OUT_W-1:0]    r_out_value;
    logic                out_free;

    assign s_axis_tready = !busy && i_rst_n;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    mlp_ctrl #(
        .INPUT_COUNT(INPUT_COUNT), .HIDDEN_COUNT(HIDDEN_COUNT),
        .OUTPUT_COUNT(OUTPUT_COUNT), .WADDR_W(WADDR_W), .FADDR_W(FADDR_W),
        .HADDR_W(HADDR_W), .OADDR_W(OADDR_W)
    ) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(accept && s_axis_tuser && s_axis_tlast),
        .i_out_free(out_free), .o_busy(busy),
        .o_rd_waddr(rd_waddr), .o_rd_faddr(rd_faddr), .o_rd_haddr(rd_haddr),
        .o_hid_we(hid_we), .o_hid_waddr(hid_waddr), .o_cmd(cmd),
        .o_emit(emit), .o_node(node), .o_node_last(node_last)
    );

    mlp_datapath #(
        .INPUT_COUNT(INPUT_COUNT), .HIDDEN_COUNT(HIDDEN_COUNT),
        .WEIGHT_COUNT(WEIGHT_COUNT), .WADDR_W(WADDR_W), .FADDR_W(FADDR_W),
        .HADDR_W(HADDR_W)
    ) u_dp (
        .i_clk(i_clk),
        .i_wr_weight(accept && !s_axis_tuser),
        .i_wr_feature(accept && s_axis_tuser),
        .i_wr_index(s_axis_tdata[6:0]),
        .i_wr_value(s_axis_tdata[22:7]),
        .i_rd_waddr(rd_waddr), .i_rd_faddr(rd_faddr), .i_rd_haddr(rd_haddr),
        .i_hid_we(hid_we), .i_hid_waddr(hid_waddr), .i_cmd(cmd),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_value <= result;
            r_out_idx   <= node[0];
            r_out_last  <= node_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_value};
    assign m_axis_tuser  = r_out_idx;
    assign m_axis_tlast  = r_out_last;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !s_axis_tready)
        else $error("input taken during a pass");
    a_emit_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || m_axis_tready))
        else $error("output register overwritten");
    a_last_ends_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && node_last) |=> !busy)
        else $error("pass did not end after last node");

endmodule
`default_nettype wire
